/* rtl/ptmq_pkg.sv */
// shared types and constants for the per-thread message queue manager
package ptmq_pkg;
  localparam int SLOTS = 32;
  localparam int THREADS = 16;
  localparam int PORT_BITS = 16;
  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam logic [LW-1:0] NIL = LW'(SLOTS);

  localparam logic [2:0] FN_APPEND  = 3'd0;
  localparam logic [2:0] FN_PREPEND = 3'd1;
  localparam logic [2:0] FN_REMOVE  = 3'd2;
  localparam logic [2:0] FN_PEEK    = 3'd3;
  localparam logic [2:0] FN_FIND    = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  thread_index;
    logic [15:0] sender_port;
    logic [31:0] msg_code;
    logic [31:0] msg_arg;
    logic        has_payload;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_port;
    logic [31:0] out_code;
    logic [31:0] out_arg;
    logic        out_payload;
  } out_word_t;

  // one slot of the message store
  typedef struct packed {
    logic [PORT_BITS-1:0] sender;
    logic [31:0]          code;
    logic [31:0]          arg;
    logic                 pay;
  } slot_t;

  // request from sequencer to slot memory
  typedef struct packed {
    logic          slot_we;
    logic [SW-1:0] slot_waddr;
    slot_t         slot_wdata;
    logic          link_we;
    logic [SW-1:0] link_waddr;
    logic [LW-1:0] link_wdata;
    logic [SW-1:0] raddr;
  } mem_req_t;
endpackage

/* rtl/ptmq_slot_mem.sv */
// slot store: message fields and next links, registered read
module ptmq_slot_mem (
  input  logic              clk,
  input  ptmq_pkg::mem_req_t req,
  output ptmq_pkg::slot_t   rd_slot,
  output logic [ptmq_pkg::LW-1:0] rd_link
);
  import ptmq_pkg::*;
  slot_t         slots [SLOTS];
  logic [LW-1:0] links [SLOTS];

  always_ff @(posedge clk) begin
    if (req.slot_we) slots[req.slot_waddr] <= req.slot_wdata;
    if (req.link_we) links[req.link_waddr] <= req.link_wdata;
    rd_slot <= slots[req.raddr];
    rd_link <= links[req.raddr];
  end
endmodule

/* rtl/ptmq_free_finder.sv */
// lowest free slot search over the used bitmap, one slot a cycle
module ptmq_free_finder (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ptmq_pkg::SLOTS-1:0] used,
  output logic                      done,
  output logic                      found,
  output logic [ptmq_pkg::SW-1:0]   slot
);
  import ptmq_pkg::*;
  logic          busy;
  logic [LW-1:0] idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      found <= 1'b0;
      idx <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx <= '0;
        found <= 1'b0;
      end else if (busy) begin
        if (idx == NIL) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else if (!used[idx[SW-1:0]]) begin
          busy <= 1'b0;
          done <= 1'b1;
          found <= 1'b1;
          slot <= idx[SW-1:0];
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end
endmodule

/* rtl/per_thread_message_queue_manager.sv */
// message queue manager: per-thread linked lists over a shared slot pool
// Usage: one input channel (in_valid/in_stall/in_data) carries a command word,
// one output channel (out_valid/out_stall/out_data) returns one status word for
// every command. Commands are taken one at a time: in_stall is high from the
// accepted word until its result has left the output register.
// Steps from acceptance to out_valid:
//   append/prepend: decode, then the free slot scan for the lowest free slot
//   (one slot a cycle), which runs over the whole pool when it is full
//   remove/peek: decode, then one registered read of the head slot
//   find: decode, then a walk of up to the queue length (one slot read
//   each step through the shared slot memory port)
//   empty queue or unknown command: decode only
// A result waits in the output register while out_stall is high; the next
// command is accepted once that register has been emptied.
// Reset clears the used bitmap, queue heads, tails, lengths and the pool count;
// slot contents are not cleared and are only read after being written.
module per_thread_message_queue_manager (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ptmq_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ptmq_pkg::out_word_t out_data
);
  import ptmq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DEC   = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_RD    = 7'b0001000,
    S_HEAD  = 7'b0010000,
    S_WALK  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t               state;
  in_word_t             cmd;
  logic [SLOTS-1:0]     used;
  logic [LW-1:0]        qhead [THREADS];
  logic [LW-1:0]        qtail [THREADS];
  logic [LW-1:0]        qlen  [THREADS];
  logic [LW-1:0]        pool;
  logic [TW-1:0]        t;
  logic [LW-1:0]        cur, prev, cnt;
  mem_req_t             req;
  mem_req_t             mreq;
  slot_t                rd_slot;
  logic [LW-1:0]        rd_link;
  logic                 ff_start, ff_done, ff_found;
  logic [SW-1:0]        ff_slot;
  logic                 lw_phase;

  ptmq_slot_mem u_mem (.clk(clk), .req(mreq), .rd_slot(rd_slot), .rd_link(rd_link));
  ptmq_free_finder u_ff (.clk(clk), .rst(rst), .start(ff_start), .used(used),
    .done(ff_done), .found(ff_found), .slot(ff_slot));

  assign in_stall = (state != S_IDLE) || out_valid;

  always_comb begin
    req = '0;
    req.raddr = cur[SW-1:0];
    req.slot_wdata.sender = cmd.sender_port[PORT_BITS-1:0];
    req.slot_wdata.code = cmd.msg_code;
    req.slot_wdata.arg = cmd.msg_arg;
    req.slot_wdata.pay = cmd.has_payload;
    req.slot_waddr = ff_slot;
    ff_start = (state == S_DEC) && (cmd.func == FN_APPEND || cmd.func == FN_PREPEND);
  end

  // walk step: write ports driven from the sequencer below
  logic          lw_en;
  logic [SW-1:0] lw_addr;
  logic [LW-1:0] lw_data;
  logic          sw_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      used <= '0;
      pool <= '0;
      for (int i = 0; i < THREADS; i++) begin
        qhead[i] <= NIL;
        qtail[i] <= NIL;
        qlen[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            cmd <= in_data;
            t <= TW'(in_data.thread_index % THREADS);
            state <= S_DEC;
          end
        end
        S_DEC: begin
          cur <= qhead[t];
          prev <= NIL;
          cnt <= '0;
          case (cmd.func)
            FN_APPEND, FN_PREPEND: begin
              out_data <= '0;
              state <= S_SCAN;
            end
            FN_REMOVE, FN_PEEK, FN_FIND: begin
              if (qlen[t] == '0 || qhead[t] == NIL) begin
                out_data <= '{status: ST_EMPTY, out_port: '0, out_code: '0,
                              out_arg: '0, out_payload: 1'b0};
                state <= S_DONE;
              end else begin
                out_data <= '0;
                state <= (cmd.func == FN_FIND) ? S_WALK : S_RD;
              end
            end
            default: begin
              out_data <= '0;
              state <= S_DONE;
            end
          endcase
        end
        S_SCAN: begin
          if (ff_done) begin
            if (!ff_found || pool >= LW'(SLOTS)) begin
              out_data.status <= ST_FULL;
            end else begin
              used[ff_slot] <= 1'b1;
              pool <= pool + 1'b1;
              qlen[t] <= qlen[t] + 1'b1;
              if (cmd.func == FN_PREPEND) begin
                if (qlen[t] == '0) qtail[t] <= LW'(ff_slot);
                qhead[t] <= LW'(ff_slot);
              end else begin
                if (qlen[t] == '0) qhead[t] <= LW'(ff_slot);
                qtail[t] <= LW'(ff_slot);
              end
            end
            state <= S_DONE;
          end
        end
        S_RD: state <= S_HEAD;
        S_HEAD: begin
          out_data.out_port <= 16'(rd_slot.sender);
          out_data.out_payload <= rd_slot.pay;
          if (cmd.func == FN_REMOVE) begin
            out_data.out_code <= rd_slot.code;
            out_data.out_arg <= rd_slot.arg;
            used[cur[SW-1:0]] <= 1'b0;
            qlen[t] <= qlen[t] - 1'b1;
            if (qlen[t] == LW'(1) || rd_link == NIL) begin
              qhead[t] <= NIL;
              qtail[t] <= NIL;
            end else begin
              qhead[t] <= rd_link;
            end
            if (pool != '0) pool <= pool - 1'b1;
          end
          state <= S_DONE;
        end
        S_WALK: begin
          // alternate: issue read of cur, then test it
          if (lw_phase) begin
            if (rd_slot.sender == cmd.sender_port[PORT_BITS-1:0]) begin
              out_data.status <= ST_OK;
              if (prev != NIL) begin
                if (qtail[t] == cur) qtail[t] <= prev;
                qhead[t] <= cur;
              end
              state <= S_DONE;
            end else if (cnt + 1'b1 >= qlen[t] || rd_link == NIL) begin
              out_data.status <= ST_NOT_FOUND;
              state <= S_DONE;
            end else begin
              prev <= cur;
              cur <= rd_link;
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // find walk: phase toggles between read issue and compare
  logic [LW-1:0] head_save;
  always_ff @(posedge clk) begin
    if (rst) lw_phase <= 1'b0;
    else if (state == S_WALK) lw_phase <= !lw_phase;
    else lw_phase <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (state == S_DEC) head_save <= qhead[t];
  end

  // link writes: new slot link on append or prepend, and find unlink (two writes)
  logic          mv_pending;
  logic [SW-1:0] mv_addr;
  logic [LW-1:0] mv_data;
  always_ff @(posedge clk) begin
    if (rst) mv_pending <= 1'b0;
    else if (state == S_WALK && lw_phase && prev != NIL &&
             rd_slot.sender == cmd.sender_port[PORT_BITS-1:0]) begin
      mv_pending <= 1'b1;
      mv_addr <= cur[SW-1:0];
      mv_data <= head_save;
    end else mv_pending <= 1'b0;
  end

  always_comb begin
    sw_en = 1'b0;
    lw_en = 1'b0;
    lw_addr = ff_slot;
    lw_data = NIL;
    if (state == S_SCAN && ff_done && ff_found && pool < LW'(SLOTS)) begin
      sw_en = 1'b1;
      lw_en = 1'b1;
      if (cmd.func == FN_PREPEND) lw_data = qhead[t];
    end else if (state == S_WALK && lw_phase && prev != NIL &&
                 rd_slot.sender == cmd.sender_port[PORT_BITS-1:0]) begin
      lw_en = 1'b1;
      lw_addr = prev[SW-1:0];
      lw_data = rd_link;
    end else if (mv_pending) begin
      lw_en = 1'b1;
      lw_addr = mv_addr;
      lw_data = mv_data;
    end
  end

  // append also links the old tail; done in the cycle after the slot write
  logic          tl_pending;
  logic [SW-1:0] tl_addr;
  logic [SW-1:0] tl_data;
  always_ff @(posedge clk) begin
    if (rst) tl_pending <= 1'b0;
    else begin
      tl_pending <= sw_en && cmd.func == FN_APPEND && qlen[t] != '0 && qtail[t] != NIL;
      tl_addr <= qtail[t][SW-1:0];
      tl_data <= ff_slot;
    end
  end

  always_comb begin
    mem_req_t r;
    r = req;
    r.slot_we = sw_en;
    r.link_we = lw_en || tl_pending;
    r.link_waddr = tl_pending ? tl_addr : lw_addr;
    r.link_wdata = tl_pending ? LW'(tl_data) : lw_data;
    mreq = r;
  end
endmodule

/* rtl/ptmq_checker.sv */
// port-level checks for the message queue manager, bound to the top level
module ptmq_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ptmq_pkg::out_word_t out_data
);
  import ptmq_pkg::*;
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted while busy");
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid out of reset");
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("result too soon");
endmodule

bind per_thread_message_queue_manager ptmq_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));

/* tb/sv/ptmq_checker.sv */
// checker for the message queue manager: watches both channels, predicts and compares
module ptmq_tb_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  ptmq_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  ptmq_pkg::out_word_t out_data,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ptmq_pkg::*;

  logic [SLOTS-1:0]     used;
  logic [15:0]          snd [SLOTS];
  logic [31:0]          code [SLOTS];
  logic [31:0]          arg [SLOTS];
  logic                 pay [SLOTS];
  int                   link [SLOTS];
  int                   head [THREADS];
  int                   tail [THREADS];
  int                   qlen [THREADS];
  int                   pool;
  out_word_t            expected_words[$];

  function automatic out_word_t apply_command(input in_word_t w);
    out_word_t r;
    int t, idx, h, prev, cur;
    r = '0;
    t = int'(w.thread_index) % THREADS;
    case (w.func)
      FN_APPEND, FN_PREPEND: begin
        idx = SLOTS;
        for (int s = SLOTS - 1; s >= 0; s--) if (!used[s]) idx = s;
        if (idx == SLOTS || pool >= SLOTS) r.status = ST_FULL;
        else begin
          used[idx] = 1'b1;
          snd[idx] = w.sender_port;
          code[idx] = w.msg_code;
          arg[idx] = w.msg_arg;
          pay[idx] = w.has_payload;
          if (w.func == FN_PREPEND) begin
            if (qlen[t] == 0) tail[t] = idx;
            link[idx] = head[t];
            head[t] = idx;
          end else begin
            if (qlen[t] == 0) head[t] = idx;
            else link[tail[t]] = idx;
            link[idx] = SLOTS;
            tail[t] = idx;
          end
          pool++;
          qlen[t]++;
        end
      end
      FN_REMOVE, FN_PEEK: begin
        h = head[t];
        if (qlen[t] == 0) r.status = ST_EMPTY;
        else begin
          r.out_port = snd[h];
          r.out_payload = pay[h];
          if (w.func == FN_REMOVE) begin
            r.out_code = code[h];
            r.out_arg = arg[h];
            used[h] = 1'b0;
            head[t] = link[h];
            qlen[t]--;
            if (qlen[t] == 0) begin
              head[t] = SLOTS;
              tail[t] = SLOTS;
            end
            pool--;
          end
        end
      end
      FN_FIND: begin
        if (qlen[t] == 0) r.status = ST_EMPTY;
        else begin
          r.status = ST_NOT_FOUND;
          prev = SLOTS;
          cur = head[t];
          for (int n = 0; n < qlen[t]; n++) begin
            if (snd[cur] == w.sender_port) begin
              r.status = ST_OK;
              if (prev != SLOTS) begin
                link[prev] = link[cur];
                if (tail[t] == cur) tail[t] = prev;
                link[cur] = head[t];
                head[t] = cur;
              end
              break;
            end
            prev = cur;
            cur = link[cur];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t e;
    if (rst) begin
      used <= '0;
      pool <= 0;
      for (int i = 0; i < THREADS; i++) begin
        head[i] <= SLOTS;
        tail[i] <= SLOTS;
        qlen[i] <= 0;
      end
      expected_words.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (in_valid && !in_stall) expected_words.push_back(apply_command(in_data));
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result word %h", out_data);
        end else begin
          e = expected_words.pop_front();
          if (e !== out_data) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display({"mismatch: exp st=%0d port=%h code=%h arg=%h pay=%b",
                        " got st=%0d port=%h code=%h arg=%h pay=%b"},
                e.status, e.out_port, e.out_code, e.out_arg, e.out_payload,
                out_data.status, out_data.out_port, out_data.out_code,
                out_data.out_arg, out_data.out_payload);
          end
        end
      end
      pending <= expected_words.size();
    end
  end
endmodule

/* tb/sv/per_thread_message_queue_manager_tb.sv */
// stimulus and verdict for the per-thread message queue manager
module per_thread_message_queue_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptmq_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  int        fail_count, pending;
  bit        hold_off = 1'b0;
  bit        quiet_rx = 1'b0;
  int        idle_cycles = 0;
  int        port_pool[4] = '{16'h0000, 16'hffff, 16'h1234, 16'ha5a5};

  always #2 clk = ~clk;

  per_thread_message_queue_manager u_dut (.*);

  ptmq_tb_checker u_chk (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .fail_count, .pending
  );

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (rst || hold_off || quiet_rx) out_stall <= hold_off;
    else out_stall <= ($urandom_range(0, 99) < 30);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("[per_thread_message_queue_manager] ERROR");
      $finish;
    end
  end

  // valid stays high after the word is taken; the caller drops it before a gap
  task automatic send_word(input in_word_t w);
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic in_word_t make_word(input logic [2:0] f, input int t, input int p);
    in_word_t w;
    w.func = f;
    w.thread_index = 4'(t);
    w.sender_port = 16'(p);
    w.msg_code = $urandom;
    w.msg_arg = $urandom;
    w.has_payload = 1'($urandom_range(0, 1));
    return w;
  endfunction

  task automatic random_command(input bit busy_pool);
    int r, t;
    logic [2:0] f;
    r = $urandom_range(0, 99);
    t = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 3);
    if (r < (busy_pool ? 40 : 25)) f = FN_APPEND;
    else if (r < (busy_pool ? 50 : 35)) f = FN_PREPEND;
    else if (r < 65) f = FN_REMOVE;
    else if (r < 75) f = FN_PEEK;
    else if (r < 97) f = FN_FIND;
    else f = 3'($urandom_range(5, 7));
    send_word(make_word(f, t,
      $urandom_range(0, 4) == 0 ? $urandom : port_pool[$urandom_range(0, 3)]));
  endtask

  initial begin
    int burst;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empties, unknown codes, fill, full pool, find cases, drains
    send_word(make_word(FN_REMOVE, 0, 0));
    send_word(make_word(FN_PEEK, 15, 0));
    send_word(make_word(FN_FIND, 3, 0));
    send_word(make_word(3'd5, 1, 16'hffff));
    send_word(make_word(3'd7, 2, 0));
    for (int i = 0; i < 32; i++)
      send_word(make_word(i[0] ? FN_PREPEND : FN_APPEND, i % 2 + 14, (i * 7) & 3));
    send_word(make_word(FN_APPEND, 5, 16'hffff));
    send_word(make_word(FN_FIND, 14, 0));
    send_word(make_word(FN_FIND, 14, 3));
    send_word(make_word(FN_FIND, 15, 16'hbeef));
    send_word(make_word(FN_PEEK, 14, 0));
    for (int i = 0; i < 33; i++) send_word(make_word(FN_REMOVE, i % 2 + 14, 0));
    in_valid <= 1'b0;
    // pause until every result is back
    while (pending != 0 || out_valid) @(posedge clk);
    // long receiver hold-off while commands keep coming
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
      for (int i = 0; i < 20; i++) random_command(1'b1);
    join
    for (int n = 0; n < 1750;) begin
      burst = $urandom_range(1, 30);
      quiet_rx <= ($urandom_range(0, 5) == 0);
      for (int k = 0; k < burst; k++) begin
        random_command(n % 600 < 300);
        n++;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    quiet_rx <= 1'b0;
    while (pending != 0 || out_valid) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("[per_thread_message_queue_manager] OK");
    else $display("[per_thread_message_queue_manager] ERROR");
    $finish;
  end
endmodule
